// ===== sv/assert_macros.svh =====
// Assertion macros shared by the formatter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== sv/itf_pkg.sv =====
// Package for the integer-to-text formatter: item types, format codes,
// derived digit counts and the digit-to-ASCII function. No dependencies.
package itf_pkg;

  localparam int ValueWidth = 64;
  localparam int FieldWidth = 64;
  localparam int PadWidth   = ((ValueWidth + 3) / 4) * 4;
  localparam int ConvSteps  = PadWidth / 4;
  localparam int StepWidth  = $clog2(ConvSteps + 1);
  localparam int HexDigits  = PadWidth / 4;
  localparam int OctDigits  = (ValueWidth + 2) / 3;
  localparam int OctWidth   = OctDigits * 3;
  localparam int DecDigits  = (ValueWidth * 30103) / 100000 + 1;
  localparam int BcdWidth   = DecDigits * 4;
  localparam int MaxDigits  = (OctDigits > DecDigits) ? OctDigits : DecDigits;
  localparam int DigWidth   = MaxDigits * 4;
  localparam int CntWidth   = $clog2(MaxDigits + 1);

  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharMinus = 7'h2D;
  localparam logic [6:0] CharA     = 7'h61;

  typedef enum logic [1:0] {
    FmtUdec = 2'd0,
    FmtSdec = 2'd1,
    FmtHex  = 2'd2,
    FmtOct  = 2'd3
  } fmt_e;

  typedef struct packed {
    logic [1:0]            func;
    logic [FieldWidth-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic conv_step;
    logic load_dig;
    logic shift_dig;
    logic sel_sign;
  } itf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_dec;
    logic is_neg;
    logic top_zero;
    logic cnt_one;
  } itf_status_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CharZero + 7'(d);
    end else begin
      c = CharA + 7'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// ===== sv/itf_dpath.sv =====
// Formatter datapath: operand and magnitude registers, shift-add-3 BCD
// converter, left-aligned digit register and character output. Uses itf_pkg.
`include "assert_macros.svh"

module itf_dpath import itf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_item_i,
  input  itf_cmd_t    cmd_i,
  output itf_status_t st_o,
  output out_item_t   out_item_o
);

  logic [1:0]            func_q, func_d;
  logic                  neg_q, neg_d;
  logic [PadWidth-1:0]   bin_q, bin_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d;
  logic [DigWidth-1:0]   dig_q, dig_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;

  logic [ValueWidth-1:0] in_val;
  logic                  in_neg;
  logic [ValueWidth-1:0] in_mag;
  logic [BcdWidth-1:0]   bcd_nx;
  logic [PadWidth-1:0]   bin_nx;
  logic [OctWidth-1:0]   oct_bits;
  logic [DigWidth-1:0]   oct_dig;
  logic [3:0]            top_dig;

  // Drop bits above the value width; take the magnitude for signed input.
  assign in_val = in_item_i.value[ValueWidth-1:0];
  assign in_neg = (in_item_i.func == FmtSdec) && in_val[ValueWidth-1];
  assign in_mag = in_neg ? (~in_val + ValueWidth'(1)) : in_val;

  // Four shift-add-3 steps per cycle.
  always_comb begin
    bcd_nx = bcd_q;
    bin_nx = bin_q;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < DecDigits; j++) begin
        if (bcd_nx[4*j +: 4] >= 4'd5) begin
          bcd_nx[4*j +: 4] = bcd_nx[4*j +: 4] + 4'd3;
        end
      end
      {bcd_nx, bin_nx} = {bcd_nx[BcdWidth-2:0], bin_nx, 1'b0};
    end
  end

  // Spread octal digits into four-bit slots.
  always_comb begin
    oct_bits = OctWidth'(bin_q);
    oct_dig  = '0;
    for (int i = 0; i < OctDigits; i++) begin
      oct_dig[4*i +: 4] = {1'b0, oct_bits[3*i +: 3]};
    end
  end

  always_comb begin
    func_d = func_q;
    neg_d  = neg_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    dig_d  = dig_q;
    cnt_d  = cnt_q;
    if (cmd_i.load_in) begin
      func_d = in_item_i.func;
      neg_d  = in_neg;
      bin_d  = PadWidth'(in_mag);
      bcd_d  = '0;
    end
    if (cmd_i.conv_step) begin
      bin_d = bin_nx;
      bcd_d = bcd_nx;
    end
    if (cmd_i.load_dig) begin
      case (func_q)
        FmtHex: begin
          dig_d = DigWidth'(bin_q) << (4 * (MaxDigits - HexDigits));
          cnt_d = CntWidth'(HexDigits);
        end
        FmtOct: begin
          dig_d = oct_dig << (4 * (MaxDigits - OctDigits));
          cnt_d = CntWidth'(OctDigits);
        end
        default: begin
          dig_d = DigWidth'(bcd_q) << (4 * (MaxDigits - DecDigits));
          cnt_d = CntWidth'(DecDigits);
        end
      endcase
    end
    if (cmd_i.shift_dig) begin
      dig_d = dig_q << 4;
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    neg_q  <= neg_d;
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    dig_q  <= dig_d;
    cnt_q  <= cnt_d;
  end

  assign top_dig = dig_q[DigWidth-1 -: 4];

  assign st_o.is_dec   = (func_q == FmtUdec) || (func_q == FmtSdec);
  assign st_o.is_neg   = neg_q;
  assign st_o.top_zero = (top_dig == 4'd0);
  assign st_o.cnt_one  = (cnt_q == CntWidth'(1));

  assign out_item_o.char_code = cmd_i.sel_sign ? CharMinus : digit_char(top_dig);
  assign out_item_o.last      = st_o.cnt_one && !cmd_i.sel_sign;

  `ASSERT_PROP(a_shift_keeps_digit, clk_i, rst_ni,
    cmd_i.shift_dig |-> (cnt_q > CntWidth'(1)), "digit shift would drop the final digit")

endmodule

// ===== sv/itf_ctrl.sv =====
// Formatter controller: one-hot state machine and conversion step counter.
// Drives datapath commands and both handshakes. Uses itf_pkg.
`include "assert_macros.svh"

module itf_ctrl import itf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  itf_status_t st_i,
  output itf_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StConv = 6'b000010,
    StLoad = 6'b000100,
    StSkip = 6'b001000,
    StSign = 6'b010000,
    StEmit = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [StepWidth-1:0] step_q, step_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          step_d  = StepWidth'(ConvSteps);
          state_d = StConv;
        end
      end
      StConv: begin
        cmd_o.conv_step = st_i.is_dec;
        step_d          = step_q - StepWidth'(1);
        if (!st_i.is_dec || (step_q == StepWidth'(1))) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load_dig = 1'b1;
        state_d        = StSkip;
      end
      StSkip: begin
        // Drop leading zero digits, but keep at least one.
        if (st_i.top_zero && !st_i.cnt_one) begin
          cmd_o.shift_dig = 1'b1;
        end else if (st_i.is_neg) begin
          state_d = StSign;
        end else begin
          state_d = StEmit;
        end
      end
      StSign: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_sign = 1'b1;
        if (out_ready_i) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (st_i.cnt_one) begin
            state_d = StIdle;
          end else begin
            cmd_o.shift_dig = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  `ASSERT_NEVER(a_ready_while_emitting, clk_i, rst_ni, in_ready_o && out_valid_o,
    "input taken while characters are still being emitted")
  `ASSERT_PROP(a_conv_bounded, clk_i, rst_ni,
    (state_q == StConv) |-> (step_q != StepWidth'(0)), "conversion ran past its step count")

endmodule

// ===== sv/integer_to_text_formatter.sv =====
// Integer-to-text formatter top level: joins controller and datapath.
// Depends on itf_pkg, itf_ctrl, itf_dpath and assert_macros.svh.
//
// Usage: present a value and a format code on the input channel
// (in_valid_i / in_ready_o / in_item_i). Formats: unsigned decimal, signed
// decimal, lowercase hex, octal. The text leaves on the output channel
// (out_valid_o / out_ready_i / out_item_o), one ASCII character per item,
// most significant first, with last set on the final character. No leading
// zeros are sent; zero gives "0"; a negative signed value gets a leading '-'.
//
// Timing: one value is worked on at a time; in_ready_o is high only while
// idle. After the accepting edge, decimal runs the shift-add-3 conversion
// loop (four bits per cycle); hex and octal skip the conversion steps.
// Then the digit register is loaded and the leading zero digits are dropped,
// keeping at least one. Characters then leave one per cycle while the
// receiver is ready.
// Reset returns the controller to idle; no partial text survives it.
// When the receiver stalls, the current character and last flag hold.
`include "assert_macros.svh"

module integer_to_text_formatter import itf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  itf_cmd_t    cmd;
  itf_status_t st;

  // Sequence the work: accept, convert, align, emit.
  itf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // Hold the operand, build the digits and form each character.
  itf_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_item_o (out_item_o)
  );

  `ASSERT_PROP(a_no_same_cycle_output, clk_i, rst_ni,
    (in_valid_i && in_ready_o) |=> !out_valid_o, "character shown right after accept")
  `ASSERT_PROP(a_idle_after_last, clk_i, rst_ni,
    (out_valid_o && out_ready_i && out_item_o.last) |=> in_ready_o,
    "block not idle after the final character")

endmodule
